// File: sv/gfa_pkg.sv
// ----------------------------------------------------------------------------
// gfa_pkg
// Shared types and constants for the GF(2^n) arithmetic unit.
// ----------------------------------------------------------------------------
package gfa_pkg;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_MUL = 2'd1,
    KIND_INV = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  // field polynomial after reset, x^8 + x^4 + x^3 + x + 1
  localparam int unsigned POLY_RESET = 32'h11b;

endpackage

// File: sv/gfa_bitlen.sv
// ----------------------------------------------------------------------------
// gfa_bitlen
// Bit length of a polynomial over GF(2): index of the leading one plus one.
// ----------------------------------------------------------------------------
module gfa_bitlen #(
  parameter int unsigned W = 16
) (
  input  logic [W-1:0]             x_i,
  output logic [$clog2(W+1)-1:0]   len_o
);

  localparam int unsigned LW = $clog2(W + 1);

  always_comb begin
    len_o = '0;
    for (int unsigned i = 0; i < W; i++) begin
      if (x_i[i]) begin
        len_o = LW'(i + 1);
      end
    end
  end

endmodule

// File: sv/gfa_shxor.sv
// ----------------------------------------------------------------------------
// gfa_shxor
// Shift and add unit over GF(2): x ^ (y << sh), truncated to the width of x.
// ----------------------------------------------------------------------------
module gfa_shxor #(
  parameter int unsigned XW = 16,
  parameter int unsigned YW = 9,
  parameter int unsigned SW = 4
) (
  input  logic [XW-1:0] x_i,
  input  logic [YW-1:0] y_i,
  input  logic [SW-1:0] sh_i,
  output logic [XW-1:0] z_o
);

  logic [XW-1:0] y_ext;

  assign y_ext = XW'(y_i);
  assign z_o   = x_i ^ (y_ext << sh_i);

endmodule

// File: sv/gf256_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit
// GF(2^n) add, multiply, inverse and divide over a programmable polynomial.
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_stall_o is high from the cycle after an
// item is taken until its result is moved into the output register. All work
// runs through two shift-and-xor units, two bit-length units and a small
// sequencer. Add goes straight to the finish state. Multiply handles one bit
// of operand_b per cycle up to its leading one, then does one reduction step
// per cycle. Inverse runs extended Euclid, one degree-reduction or swap step
// per cycle. Divide is an inverse followed by a multiply. A stalled output
// holds the finish state until the output register is free. The output
// register lets the next item be taken while a result waits.
module gf256_arithmetic_unit #(
  parameter int unsigned FIELD_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gfa_pkg::kind_e        kind_i,
  input  logic [FIELD_BITS-1:0] operand_a_i,
  input  logic [FIELD_BITS-1:0] operand_b_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [FIELD_BITS-1:0] result_o,
  input  logic                  cfg_we_i,
  input  logic [FIELD_BITS:0]   cfg_wdata_i
);

  import gfa_pkg::*;

  localparam int unsigned PW  = FIELD_BITS + 1;
  localparam int unsigned XW  = 2 * FIELD_BITS;
  localparam int unsigned LXW = $clog2(XW + 1);
  localparam int unsigned LYW = $clog2(PW + 1);
  localparam int unsigned SW  = $clog2(XW);
  localparam int unsigned TSW = $clog2(PW);
  localparam int unsigned CW  = $clog2(PW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RED  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic [PW-1:0]         poly_q;
  logic [FIELD_BITS-1:0] result_q, result_d;

  // x holds the Euclid dividend, the product accumulator or the remainder
  logic [XW-1:0]         x_q, x_d;
  logic [PW-1:0]         r_q, r_d;
  logic [PW-1:0]         t_q, t_d;
  logic [PW-1:0]         tp_q, tp_d;
  logic [PW-1:0]         m_q, m_d;
  logic [FIELD_BITS-1:0] a_q, a_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  kind_e                 kind_q, kind_d;

  logic [PW-1:0]  y_sel;
  logic [SW-1:0]  sh_sel;
  logic [LXW-1:0] len_x;
  logic [LYW-1:0] len_y;
  logic [LXW-1:0] len_diff;
  logic [XW-1:0]  shx_out;
  logic [PW-1:0]  t_out;
  logic           can_sub;
  logic           out_free;

  gfa_bitlen #(.W(XW)) u_len_x (
    .x_i   (x_q),
    .len_o (len_x)
  );

  gfa_bitlen #(.W(PW)) u_len_y (
    .x_i   (y_sel),
    .len_o (len_y)
  );

  gfa_shxor #(.XW(XW), .YW(PW), .SW(SW)) u_shxor (
    .x_i  (x_q),
    .y_i  (y_sel),
    .sh_i (sh_sel),
    .z_o  (shx_out)
  );

  // bezout coefficient update, tp ^= t << sh
  gfa_shxor #(.XW(PW), .YW(PW), .SW(TSW)) u_shxor_t (
    .x_i  (tp_q),
    .y_i  (t_q),
    .sh_i (sh_sel[TSW-1:0]),
    .z_o  (t_out)
  );

  always_comb begin
    unique case (state_q)
      S_INV:   y_sel = r_q;
      S_MUL:   y_sel = PW'(a_q);
      default: y_sel = poly_q;
    endcase
  end

  assign len_diff = len_x - LXW'(len_y);
  assign sh_sel   = (state_q == S_MUL) ? SW'(cnt_q) : len_diff[SW-1:0];
  assign can_sub  = (x_q != '0) && (y_sel != '0) && (len_x >= LXW'(len_y));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    r_d         = r_q;
    t_d         = t_q;
    tp_d        = tp_q;
    m_d         = m_q;
    a_d         = a_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;

    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          a_d    = operand_a_i;
          kind_d = kind_i;
          x_d    = '0;
          cnt_d  = '0;
          m_d    = PW'(operand_b_i);
          t_d    = PW'(1);
          tp_d   = '0;
          r_d    = PW'(operand_a_i);
          unique case (kind_i)
            KIND_ADD: begin
              x_d     = XW'(operand_a_i ^ operand_b_i);
              state_d = S_FIN;
            end
            KIND_MUL: begin
              state_d = S_MUL;
            end
            KIND_INV: begin
              x_d     = XW'(poly_q);
              state_d = S_INV;
            end
            KIND_DIV: begin
              x_d     = XW'(poly_q);
              r_d     = PW'(operand_b_i);
              state_d = S_INV;
            end
          endcase
        end
      end
      S_INV: begin
        if (r_q == '0) begin
          if (kind_q == KIND_DIV) begin
            m_d     = tp_q;
            x_d     = '0;
            cnt_d   = '0;
            state_d = S_MUL;
          end else begin
            x_d     = XW'(tp_q);
            state_d = S_FIN;
          end
        end else if (can_sub) begin
          x_d  = shx_out;
          tp_d = t_out;
        end else begin
          // remainder done: rotate (rp, r) and (tp, t)
          x_d  = XW'(r_q);
          r_d  = x_q[PW-1:0];
          t_d  = tp_q;
          tp_d = t_q;
        end
      end
      S_MUL: begin
        if (m_q == '0) begin
          state_d = S_RED;
        end else begin
          if (m_q[0]) begin
            x_d = shx_out;
          end
          m_d   = m_q >> 1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_RED: begin
        if (can_sub) begin
          x_d = shx_out;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          result_d    = x_q[FIELD_BITS-1:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      poly_q      <= PW'(POLY_RESET);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        poly_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    r_q      <= r_d;
    t_q      <= t_d;
    tp_q     <= tp_d;
    m_q      <= m_d;
    a_q      <= a_d;
    cnt_q    <= cnt_d;
    kind_q   <= kind_d;
    result_q <= result_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// File: sv/gfa_checker.sv
// ----------------------------------------------------------------------------
// gfa_checker
// Port-level checks for the GF(2^n) arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module gfa_checker #(
  parameter int unsigned FIELD_BITS = 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [FIELD_BITS-1:0] result_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_o)))
    else $error("stalled result changed");

  // the block is busy after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item taken but block not busy");

  // a new result only comes out of a busy block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in work");

  // the block goes idle only as it hands over a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("went idle without a result");

endmodule

bind gf256_arithmetic_unit gfa_checker #(.FIELD_BITS(FIELD_BITS)) u_gfa_checker (.*);

// File: tb/gf256_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit_tb
// Drives add, multiply, inverse and divide items through the GF(2^8) unit
// under several reduction polynomials, irreducible and reducible, and checks
// every result against an extended-Euclid predictor, with random gaps on the
// input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module gf256_arithmetic_unit_tb;

  import gfa_pkg::*;

  typedef struct {
    kind_e      kind;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] res;
  } gf_expectation_t;

  class gf_expected_results;
    gf_expectation_t pending[$];
    logic [8:0]      poly;
    int unsigned     errors;

    function new();
      poly   = 9'(POLY_RESET);
      errors = 0;
    endfunction

    function void set_poly(logic [8:0] value);
      poly = value;
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction

    function int unsigned bit_len(logic [31:0] x);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 32; i++) begin
        if (x[i]) begin
          n = i + 1;
        end
      end
      return n;
    endfunction

    // polynomial division over GF(2), remainder through rem
    function logic [31:0] poly_div(logic [31:0] num, logic [31:0] den,
                                   output logic [31:0] rem);
      logic [31:0] quot;
      int unsigned dlen;
      int unsigned sh;
      quot = '0;
      if (den == 0) begin
        rem = num;
        return quot;
      end
      dlen = bit_len(den);
      while (num != 0 && bit_len(num) >= dlen) begin
        sh   = bit_len(num) - dlen;
        quot = quot | (32'd1 << sh);
        num  = num ^ (den << sh);
      end
      rem = num;
      return quot;
    endfunction

    function logic [31:0] carryless_mul(logic [31:0] x, logic [31:0] y);
      logic [31:0] acc;
      acc = '0;
      for (int i = 0; i < 16; i++) begin
        if (x[i]) begin
          acc = acc ^ (y << i);
        end
      end
      return acc;
    endfunction

    function logic [31:0] reduce_mod_poly(logic [31:0] x);
      logic [31:0] rem;
      void'(poly_div(x, {23'd0, poly}, rem));
      return rem;
    endfunction

    // bezout coefficient of x from extended euclid on (poly, x)
    function logic [31:0] euclid_inverse(logic [31:0] x);
      logic [31:0] r_prev, r_cur, t_prev, t_cur, quot, rem, t_next;
      r_prev = {23'd0, poly};
      r_cur  = x;
      t_prev = '0;
      t_cur  = 32'd1;
      while (r_cur != 0) begin
        quot   = poly_div(r_prev, r_cur, rem);
        t_next = t_prev ^ carryless_mul(quot, t_cur);
        r_prev = r_cur;
        r_cur  = rem;
        t_prev = t_cur;
        t_cur  = t_next;
      end
      return t_prev;
    endfunction

    function logic [7:0] field_op(kind_e kind, logic [7:0] a, logic [7:0] b);
      logic [31:0] full;
      case (kind)
        KIND_ADD: full = {24'd0, a ^ b};
        KIND_MUL: full = reduce_mod_poly(carryless_mul({24'd0, a}, {24'd0, b}));
        KIND_INV: full = euclid_inverse({24'd0, a});
        default:  full = reduce_mod_poly(carryless_mul({24'd0, a},
                                                       euclid_inverse({24'd0, b})));
      endcase
      return full[7:0];
    endfunction

    function void note_item(kind_e kind, logic [7:0] a, logic [7:0] b);
      gf_expectation_t e;
      e.kind = kind;
      e.a    = a;
      e.b    = b;
      e.res  = field_op(kind, a, b);
      pending.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] res);
      gf_expectation_t e;
      if (pending.size() == 0) begin
        report($sformatf("result %02h with no item outstanding", res));
        return;
      end
      e = pending.pop_front();
      if (res !== e.res) begin
        report($sformatf("%s a=%02h b=%02h poly=%03h: got %02h, want %02h",
                         e.kind.name(), e.a, e.b, poly, res, e.res));
      end
    endtask
  endclass

  localparam int unsigned STUCK_LIMIT = 4000;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  kind_e      kind_i;
  logic [7:0] operand_a_i;
  logic [7:0] operand_b_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] result_o;
  logic       cfg_we_i;
  logic [8:0] cfg_wdata_i;

  gf_expected_results board = new();
  bit                 quiet = 1'b0;
  int unsigned        stuck_cycles;

  gf256_arithmetic_unit #(
    .FIELD_BITS (8)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // output side stalls at random unless quiet
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= !quiet && ($urandom_range(99) < 33);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(result_o);
    end
  end

  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(kind_e kind, logic [7:0] a, logic [7:0] b);
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    operand_a_i <= a;
    operand_b_i <= b;
    do begin
      @(posedge clk_i);
    end while (in_stall_o !== 1'b0);
    board.note_item(kind, a, b);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_poly(logic [8:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_poly(value);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_operand();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0:       return 8'h00;
        1:       return 8'h01;
        2:       return 8'h80;
        default: return 8'hff;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic run_random(logic [8:0] poly, int unsigned count, bit no_gaps,
                            int unsigned pause_at);
    write_poly(poly);
    quiet = no_gaps;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == pause_at) begin
        wait_drained();
      end
      send_item(kind_e'($urandom_range(3)), pick_operand(), pick_operand());
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_ADD;
    operand_a_i = '0;
    operand_b_i = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset polynomial, field extremes and inverse of zero
    send_item(KIND_ADD, 8'h00, 8'h00);
    send_item(KIND_ADD, 8'hff, 8'hff);
    send_item(KIND_ADD, 8'ha5, 8'h5a);
    send_item(KIND_MUL, 8'h00, 8'hff);
    send_item(KIND_MUL, 8'hff, 8'hff);
    send_item(KIND_MUL, 8'h80, 8'h80);
    send_item(KIND_MUL, 8'h57, 8'h83);
    send_item(KIND_INV, 8'h00, 8'hff);
    send_item(KIND_INV, 8'h01, 8'h00);
    send_item(KIND_INV, 8'hff, 8'h00);
    send_item(KIND_INV, 8'h53, 8'ha5);
    send_item(KIND_DIV, 8'h00, 8'h00);
    send_item(KIND_DIV, 8'hff, 8'h00);
    send_item(KIND_DIV, 8'h01, 8'hff);
    send_item(KIND_DIV, 8'hff, 8'hff);
    send_item(KIND_DIV, 8'h80, 8'h01);

    // reducible polynomial x^8: euclid still runs, no true inverse
    write_poly(9'h100);
    send_item(KIND_INV, 8'h02, 8'h00);
    send_item(KIND_INV, 8'h03, 8'h00);
    send_item(KIND_MUL, 8'hff, 8'hff);
    send_item(KIND_DIV, 8'h05, 8'h06);
    write_poly(9'h1ff);
    send_item(KIND_INV, 8'hff, 8'h00);
    send_item(KIND_DIV, 8'hff, 8'h80);

    run_random(9'h11b, 230, 1'b0, 120);
    run_random(9'h100, 180, 1'b0, 1000);
    run_random(9'h1ff, 220, 1'b1, 1000);
    run_random(9'h11d, 200, 1'b0, 1000);
    run_random(9'($urandom_range(511, 256)), 200, 1'b0, 60);
    run_random(9'($urandom_range(511, 256)), 120, 1'b0, 1000);
    run_random(9'h11b, 150, 1'b0, 1000);

    wait_drained();
    repeat (100) @(negedge clk_i);
    if (board.outstanding() != 0) begin
      board.report($sformatf("%0d results never arrived", board.outstanding()));
    end
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
